@@ rtl/core/isq_pkg.sv @@
// shared types and constants for the indexed sequence store
`timescale 1ns / 1ps

package isq_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 16;
  localparam int LEN_W    = 6;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_BEFORE = 3'd3,
    OP_DELETE = 3'd4
  } isq_op_t;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value;
  } isq_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    read_valid;
    logic                    applied;
    logic                    full_drop;
    logic [LEN_W-1:0]        length;
  } isq_out_t;

  // broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] slot;
  } isq_cell_ctrl_t;

  typedef struct packed {
    logic is_read;
    logic read_ok;
    logic applied;
    logic full_drop;
  } isq_flags_t;

endpackage

@@ rtl/core/isq_cell.sv @@
// one storage cell of the sequence chain
`timescale 1ns / 1ps

module isq_cell import isq_pkg::*; (
  input  logic                    clk,
  input  isq_cell_ctrl_t          ctrl,
  input  logic [IDX_W-1:0]        idx,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic signed [VAL_W-1:0] right_value,
  input  logic signed [VAL_W-1:0] new_value,
  output logic signed [VAL_W-1:0] entry_value,
  output logic signed [VAL_W-1:0] hit_value
);

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;
  logic                    is_slot;
  logic                    above_slot;

  assign is_slot    = (idx == ctrl.slot);
  assign above_slot = (idx > ctrl.slot);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (is_slot) begin
        entry_nxt = new_value;
      end else if (above_slot) begin
        entry_nxt = left_value;
      end
    end else if (ctrl.del) begin
      if (is_slot || above_slot) begin
        entry_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_value = entry_r;
  // only the addressed cell drives the read bus
  assign hit_value   = is_slot ? entry_r : '0;

endmodule

@@ rtl/core/isq_ctrl.sv @@
// operation decode, bounds checks and count update
`timescale 1ns / 1ps

module isq_ctrl import isq_pkg::*; (
  input  logic             accept,
  input  isq_in_t          in_word,
  input  logic [CNT_W-1:0] count,
  output isq_cell_ctrl_t   cell_ctrl,
  output isq_flags_t       flags,
  output logic [CNT_W-1:0] count_nxt
);

  logic        pos_neg;
  logic [31:0] pos_ext;
  logic [31:0] cnt_ext;
  logic        in_list;
  logic        full;

  assign pos_neg = in_word.position[POS_W-1];
  assign pos_ext = 32'(unsigned'(in_word.position[POS_W-2:0]));
  assign cnt_ext = 32'(count);
  assign in_list = !pos_neg && (pos_ext < cnt_ext);
  assign full    = (cnt_ext >= 32'(CAPACITY));

  always_comb begin
    cell_ctrl      = '0;
    cell_ctrl.slot = IDX_W'(pos_ext);
    flags          = '0;
    count_nxt      = count;
    if (accept) begin
      case (in_word.op)
        OP_READ: begin
          flags.is_read = 1'b1;
          flags.read_ok = in_list;
        end
        OP_HEAD: begin
          cell_ctrl.slot = '0;
          cell_ctrl.ins  = !full;
        end
        OP_TAIL: begin
          cell_ctrl.slot = IDX_W'(count);
          cell_ctrl.ins  = !full;
        end
        OP_BEFORE: begin
          if (pos_neg) begin
            cell_ctrl.slot = '0;
            cell_ctrl.ins  = !full;
          end else if (pos_ext <= cnt_ext) begin
            cell_ctrl.ins  = !full;
          end
        end
        OP_DELETE: begin
          cell_ctrl.del = in_list;
        end
        default: begin
        end
      endcase
      // full drop only for inserts that got past the position check
      if ((in_word.op == OP_HEAD) || (in_word.op == OP_TAIL) ||
          ((in_word.op == OP_BEFORE) && (pos_neg || (pos_ext <= cnt_ext)))) begin
        flags.full_drop = full;
      end
      flags.applied = cell_ctrl.ins || cell_ctrl.del;
      if (cell_ctrl.ins) begin
        count_nxt = count + CNT_W'(1);
      end else if (cell_ctrl.del) begin
        count_nxt = count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/indexed_sequence_store_core.sv @@
// top level of the indexed sequence store: control plus a chain of cells
`timescale 1ns / 1ps

// channel   | ports                     | handshake
// ----------+---------------------------+-------------------------------------
// input     | start, busy, in_word      | word taken when start && !busy
// result    | out_valid, out_word       | one word per input, one-cycle strobe
//
// every operation is registered once: a word taken at an edge shows on out_word
// in the next cycle, and while busy is low a new word may be taken at every
// edge; the rate is set by the cell chain, which shifts all entries in parallel
// busy is high only while rst_n is low; reset clears the count and the
// result strobe, entry contents stay undefined until written
// the receiver cannot stall: each result is valid for exactly one cycle

module indexed_sequence_store_core import isq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  isq_in_t  in_word,
  output logic     out_valid,
  output isq_out_t out_word
);

  logic                    accept;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  isq_cell_ctrl_t          cell_ctrl;
  isq_flags_t              flags;

  // entry values and read-bus contributions, one per cell
  logic signed [VAL_W-1:0] entry_q  [CAPACITY];
  logic signed [VAL_W-1:0] hit_q    [CAPACITY];
  logic signed [VAL_W-1:0] read_bus;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  isq_out_t                out_word_r;
  isq_out_t                out_word_nxt;

  // no word is taken while reset is held
  assign busy   = !rst_n;
  assign accept = start && !busy;

  isq_ctrl u_ctrl (
    .accept    (accept),
    .in_word   (in_word),
    .count     (count_r),
    .cell_ctrl (cell_ctrl),
    .flags     (flags),
    .count_nxt (count_nxt)
  );

  // cell i takes from i-1 on insert and from i+1 on delete
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_value;
    logic signed [VAL_W-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_value = in_word.value;
    end else begin : g_mid_l
      assign left_value = entry_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = entry_q[i];
    end else begin : g_mid_r
      assign right_value = entry_q[i+1];
    end

    isq_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .idx         (IDX_W'(i)),
      .left_value  (left_value),
      .right_value (right_value),
      .new_value   (in_word.value),
      .entry_value (entry_q[i]),
      .hit_value   (hit_q[i])
    );
  end

  // at most one cell matches the slot, so an OR merges the read bus
  always_comb begin
    read_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_bus = read_bus | hit_q[i];
    end
  end

  // result word, registered at the edge that takes the input word
  always_comb begin
    out_valid_nxt          = accept;
    out_word_nxt           = '0;
    out_word_nxt.read_valid = flags.read_ok;
    out_word_nxt.applied   = flags.applied;
    out_word_nxt.full_drop = flags.full_drop;
    out_word_nxt.length    = LEN_W'(count_nxt);
    if (flags.is_read) begin
      // invalid positions read back as all ones
      out_word_nxt.read_value = flags.read_ok ? read_bus : '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ rtl/core/isq_checker.sv @@
// port-level checks for the indexed sequence store, bound to the top level
`timescale 1ns / 1ps

module isq_checker import isq_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input isq_out_t out_word
);

  // every word taken gives exactly one result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("no result after a taken word");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without a taken word");

  // a successful read changes nothing and drops nothing
  a_read_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.read_valid) |-> (!out_word.applied && !out_word.full_drop))
    else $error("read reported as a change");

  // a dropped insert means the store stood at capacity
  a_drop_at_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.full_drop) |->
      (!out_word.applied && (out_word.length == LEN_W'(CAPACITY))))
    else $error("full drop below capacity");

  // a change directly after a result of any kind moves the length by one
  a_length_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.applied && $past(out_valid) && $past(rst_n)) |->
      ((out_word.length == $past(out_word.length) + LEN_W'(1)) ||
       (out_word.length == $past(out_word.length) - LEN_W'(1)))
    )
    else $error("length moved by more than one");

endmodule

bind indexed_sequence_store_core isq_checker u_isq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);
